// ===== hdl/bmcd_pkg.sv =====
package bmcd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SIZE_W  = 11;
    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int SUM_W   = 5;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = SIZE_W'(480);

    // window weights: top-left, top-right, bottom-left, bottom-right
    localparam logic [SUM_W-1:0] WEIGHT_TL = SUM_W'(1);
    localparam logic [SUM_W-1:0] WEIGHT_TR = SUM_W'(3);
    localparam logic [SUM_W-1:0] WEIGHT_BL = SUM_W'(5);
    localparam logic [SUM_W-1:0] WEIGHT_BR = SUM_W'(7);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    // pixel handed from the line-store read stage to the window stage
    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             cur;
    } win_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] corner_x;
        logic [COORD_W-1:0] corner_y;
    } corner_t;

    function automatic logic [COL_W:0] clamp_width(input logic [SIZE_W-1:0] v);
        logic [COL_W:0] r;
        if (int'(v) < 2)
            r = (COL_W+1)'(2);
        else if (int'(v) > MAX_WIDTH)
            r = (COL_W+1)'(MAX_WIDTH);
        else
            r = (COL_W+1)'(v);
        return r;
    endfunction

    function automatic logic [ROW_W:0] clamp_height(input logic [SIZE_W-1:0] v);
        logic [ROW_W:0] r;
        if (int'(v) < 2)
            r = (ROW_W+1)'(2);
        else if (int'(v) > MAX_HEIGHT)
            r = (ROW_W+1)'(MAX_HEIGHT);
        else
            r = (ROW_W+1)'(v);
        return r;
    endfunction

endpackage

// ===== hdl/bmcd_pixel_if.sv =====
interface bmcd_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [bmcd_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

// ===== hdl/bmcd_corner_if.sv =====
interface bmcd_corner_if;
    logic                        valid;
    logic                        ready;
    logic [bmcd_pkg::COORD_W-1:0] corner_x;
    logic [bmcd_pkg::COORD_W-1:0] corner_y;

    modport source (output valid, output corner_x, output corner_y, input ready);
    modport sink   (input valid, input corner_x, input corner_y, output ready);
endinterface

// ===== hdl/bmcd_cfg.sv =====
module bmcd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmcd_pkg::APB_AW-1:0]   paddr,
    input  logic [bmcd_pkg::APB_DW-1:0]   pwdata,
    output logic [bmcd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [bmcd_pkg::COL_W:0]      width_eff,
    output logic [bmcd_pkg::ROW_W:0]      height_eff
);

    logic [bmcd_pkg::SIZE_W-1:0] frame_width_reg;
    logic [bmcd_pkg::SIZE_W-1:0] frame_height_reg;
    bmcd_pkg::reg_idx_t          reg_idx;
    logic                        wr_en;

    assign reg_idx = bmcd_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bmcd_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= bmcd_pkg::FRAME_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bmcd_pkg::REG_FRAME_WIDTH:
                    frame_width_reg  <= pwdata[bmcd_pkg::SIZE_W-1:0];
                bmcd_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[bmcd_pkg::SIZE_W-1:0];
                default:
                    frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bmcd_pkg::REG_FRAME_WIDTH:  prdata = bmcd_pkg::APB_DW'(frame_width_reg);
            bmcd_pkg::REG_FRAME_HEIGHT: prdata = bmcd_pkg::APB_DW'(frame_height_reg);
            default:                    prdata = '0;
        endcase
    end

    assign width_eff  = bmcd_pkg::clamp_width(frame_width_reg);
    assign height_eff = bmcd_pkg::clamp_height(frame_height_reg);

endmodule

// ===== hdl/bmcd_line_ram.sv =====
module bmcd_line_ram (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [bmcd_pkg::COL_W-1:0] rd_addr,
    output logic                       rd_data,
    input  logic                       wr_en,
    input  logic [bmcd_pkg::COL_W-1:0] wr_addr,
    input  logic                       wr_data
);

    logic mem [bmcd_pkg::MAX_WIDTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/bmcd_window.sv =====
module bmcd_window (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  bmcd_pkg::win_req_t req,
    input  logic               above,
    output logic               hit,
    output bmcd_pkg::corner_t  corner
);

    logic                        left_reg;
    logic                        above_left_reg;
    logic [bmcd_pkg::SUM_W-1:0]  sum;
    logic                        full_window;
    logic [bmcd_pkg::COL_W-1:0]  cx;
    logic [bmcd_pkg::ROW_W-1:0]  cy;
    logic                        sel_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= 1'b0;
            above_left_reg <= 1'b0;
        end
        else if (req_valid)
        begin
            left_reg       <= req.cur;
            above_left_reg <= above;
        end
    end

    assign full_window = (req.x != '0) && (req.y != '0);

    always_comb
    begin
        sum = (above_left_reg ? bmcd_pkg::WEIGHT_TL : '0)
            + (above          ? bmcd_pkg::WEIGHT_TR : '0)
            + (left_reg       ? bmcd_pkg::WEIGHT_BL : '0)
            + (req.cur        ? bmcd_pkg::WEIGHT_BR : '0);
    end

    // lone obstacle: corner is the free pixel diagonally across the window
    always_comb
    begin
        sel_hit = 1'b1;
        cx      = req.x;
        cy      = req.y;
        unique case (sum)
            bmcd_pkg::WEIGHT_TL:
            begin
                cx = req.x;
                cy = req.y;
            end
            bmcd_pkg::WEIGHT_TR:
            begin
                cx = req.x - 1'b1;
                cy = req.y;
            end
            bmcd_pkg::WEIGHT_BL:
            begin
                cx = req.x;
                cy = req.y - 1'b1;
            end
            bmcd_pkg::WEIGHT_BR:
            begin
                cx = req.x - 1'b1;
                cy = req.y - 1'b1;
            end
            default:
                sel_hit = 1'b0;
        endcase
    end

    assign hit             = req_valid && full_window && sel_hit;
    assign corner.corner_x = bmcd_pkg::COORD_W'(cx);
    assign corner.corner_y = bmcd_pkg::COORD_W'(cy);

endmodule

// ===== hdl/bmcd_out_fifo.sv =====
module bmcd_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bmcd_pkg::corner_t push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bmcd_pkg::corner_t out_data,
    output logic [1:0]        count
);

    bmcd_pkg::corner_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              pop;

    assign out_valid  = (count_reg != 2'd0);
    assign pop        = out_valid && out_ready;
    assign out_data   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign count_next = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hdl/binary_map_corner_detector.sv =====
// An accepted pixel is registered into the window stage; its corner into the queue.
// Throughput: one pixel per cycle unless corners back up; the line store does one
//   read and one write per cycle: the read for pixel N+1 with pixel N's write-back.
// A two-entry result queue lets input continue while a corner waits.
// Reset (rst_n low, asynchronous): position, window bits and queue clear, sizes
//   return to 640 x 480; line store contents are not cleared.
module binary_map_corner_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmcd_pkg::APB_AW-1:0]   paddr,
    input  logic [bmcd_pkg::APB_DW-1:0]   pwdata,
    output logic [bmcd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    bmcd_pixel_if.sink                    pixel_in,
    bmcd_corner_if.source                 corner_out
);

    logic [bmcd_pkg::COL_W:0]   width_eff;
    logic [bmcd_pkg::ROW_W:0]   height_eff;
    logic [bmcd_pkg::COL_W-1:0] col_reg;
    logic [bmcd_pkg::COL_W-1:0] col_next;
    logic [bmcd_pkg::ROW_W-1:0] row_reg;
    logic [bmcd_pkg::ROW_W-1:0] row_next;
    logic                       s1_valid_reg;
    bmcd_pkg::win_req_t         s1_req_reg;
    logic                       above;
    logic                       hit;
    bmcd_pkg::corner_t          corner;
    bmcd_pkg::corner_t          out_data;
    logic [1:0]                 fifo_count;
    logic                       pop;
    logic [2:0]                 occupancy;
    logic                       accept;
    logic                       cur;

    bmcd_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .width_eff  (width_eff),
        .height_eff (height_eff)
    );

    // results still owed after this edge; keep room so the window stage never stalls
    assign pop       = corner_out.valid && corner_out.ready;
    assign occupancy = 3'(fifo_count) + 3'(s1_valid_reg) - 3'(pop);
    assign pixel_in.ready = (occupancy <= 3'd1);
    assign accept    = pixel_in.valid && pixel_in.ready;
    assign cur       = (pixel_in.pixel_value == '0);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if ((bmcd_pkg::COL_W+1)'(col_reg) + 1'b1 >= width_eff)
        begin
            col_next = '0;
            if ((bmcd_pkg::ROW_W+1)'(row_reg) + 1'b1 >= height_eff)
                row_next = '0;
            else
                row_next = row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg.x   <= col_reg;
            s1_req_reg.y   <= row_reg;
            s1_req_reg.cur <= cur;
        end
    end

    // consecutive pixels never share a column, so read and write-back never collide
    bmcd_line_ram u_line_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (above),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_req_reg.x),
        .wr_data (s1_req_reg.cur)
    );

    bmcd_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s1_valid_reg),
        .req       (s1_req_reg),
        .above     (above),
        .hit       (hit),
        .corner    (corner)
    );

    bmcd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (hit),
        .push_data (corner),
        .out_valid (corner_out.valid),
        .out_ready (corner_out.ready),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign corner_out.corner_x = out_data.corner_x;
    assign corner_out.corner_y = out_data.corner_y;

endmodule

// ===== hdl/bmcd_checker.sv =====
module bmcd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bmcd_pkg::COORD_W-1:0]  corner_x,
    input logic [bmcd_pkg::COORD_W-1:0]  corner_y
);

    // input only backs up when corners are waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no corner pending");

    // a fresh corner traces back to an accepted pixel, registered through the window stage and the result queue
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("corner appeared without a matching pixel request");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(corner_x) && $stable(corner_y))
        else $error("stalled corner changed or dropped");

endmodule

bind binary_map_corner_detector bmcd_checker u_bmcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .out_valid (corner_out.valid),
    .out_ready (corner_out.ready),
    .corner_x  (corner_out.corner_x),
    .corner_y  (corner_out.corner_y)
);
